/* hw/rtl/lzrd_pkg.sv */
// Shared types and constants of the LZSS ring window decoder.
// No dependencies; every other file of the block imports this package.
package lzrd_pkg;

    localparam int RING_DEPTH_DEF = 4096;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 31;
    localparam int BUDGET_W   = 33;
    localparam int CONSUMED_W = 32;
    localparam int KIND_W     = 2;
    localparam int DIST_W     = 12;
    localparam int LEN_W      = 5;

    // Configuration register indexes
    localparam logic CFG_PACKED_SIZE = 1'b0;
    localparam logic CFG_MAX_OUTPUT  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIMIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd3;

    // Flag word and budget costs
    localparam logic [LEN_W-1:0]    FLAGS_PER_WORD = 5'd16;
    localparam logic [BUDGET_W-1:0] COST_FLAG      = 33'd2;
    localparam logic [BUDGET_W-1:0] COST_LITERAL   = 33'd1;
    localparam logic [BUDGET_W-1:0] COST_MATCH     = 33'd2;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_ACTIVE,
        RUN_DONE,
        RUN_FAIL
    } run_t;

    typedef enum logic [1:0] {
        PH_FLAG_LO,
        PH_FLAG_HI,
        PH_ITEM,
        PH_MATCH2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_MRD,
        ST_COPY,
        ST_MARK
    } state_t;

endpackage

/* hw/rtl/lzrd_if.sv */
// Valid/ready channel interfaces for compressed input and decoded results.
// Depends on lzrd_pkg for field widths.
interface lzrd_in_if
    import lzrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_start;
    logic              source_end;

    modport source (output valid, output in_byte, output stream_start, output source_end,
                    input ready);
    modport sink   (input valid, input in_byte, input stream_start, input source_end,
                    output ready);
endinterface

interface lzrd_out_if
    import lzrd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BYTE_W-1:0]     out_byte;
    logic [KIND_W-1:0]     kind;
    logic [CONSUMED_W-1:0] consumed;
    logic                  last;

    modport source (output valid, output out_byte, output kind, output consumed, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input consumed, input last,
                    output ready);
endinterface

/* hw/rtl/lzss_ring_window_decoder_unit.sv */
// LZSS decoder top level with a 4096-byte ring window held in lzrd_ring.
// Depends on lzrd_pkg, lzrd_in_if / lzrd_out_if and lzrd_ring.
//
// Channel     Dir  Item contents
// ----------  ---  ---------------------------------------------------
// packed_ch   in   in_byte, stream_start, source_end
// decoded_ch  out  out_byte, kind, consumed, last
// cfg_*       in   write enable, register index, 31-bit data
//
// One compressed byte is taken per item. Flag bytes and the first byte of a
// match give no result. A literal passes through ST_LIT; a match passes through
// ST_MRD and ST_COPY, with one ring read per copied byte (up to 16 bytes).
// Done and truncation markers pass through ST_MARK; a limit error takes the
// place of the byte it stops. Output backpressure stalls the copy in place. Reset
// needs no clearing pass: a fill mark tells which ring entries the current
// stream has written, and unwritten entries read as zero.
module lzss_ring_window_decoder_unit
    import lzrd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    lzrd_in_if.sink           packed_ch,
    lzrd_out_if.source        decoded_ch
);

    localparam int AW = $clog2(RING_DEPTH);

    // Control state
    state_t                 state_reg, state_next;
    run_t                   run_reg, run_next;
    phase_t                 phase_reg, phase_next;
    logic [15:0]            flag_bits_reg, flag_bits_next;
    logic [LEN_W-1:0]       flags_left_reg, flags_left_next;
    logic [BYTE_W-1:0]      held_reg, held_next;
    logic [BUDGET_W-1:0]    budget_reg, budget_next;
    logic [CFG_W-1:0]       count_reg, count_next;
    logic [CONSUMED_W-1:0]  consumed_reg, consumed_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic                   full_reg, full_next;
    logic                   at_end_reg, at_end_next;
    logic [AW-1:0]          src_reg, src_next;
    logic [LEN_W-1:0]       remain_reg, remain_next;
    logic                   fwd_reg, fwd_next;
    logic                   rvalid_reg, rvalid_next;
    logic [KIND_W-1:0]      mark_kind_reg, mark_kind_next;
    logic [CFG_W-1:0]       packed_size_reg;
    logic [CFG_W-1:0]       max_output_reg;
    logic                   out_valid_reg, out_valid_next;

    // Payload registers
    logic [BYTE_W-1:0]      lit_reg, lit_next;
    logic [BYTE_W-1:0]      fwd_data_reg, fwd_data_next;
    logic [CONSUMED_W-1:0]  mark_cons_reg, mark_cons_next;
    logic [BYTE_W-1:0]      out_byte_reg, out_byte_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [CONSUMED_W-1:0]  out_cons_reg, out_cons_next;
    logic                   out_last_reg, out_last_next;

    // Ring port
    logic                   ring_we;
    logic [BYTE_W-1:0]      ring_wdata;
    logic                   ring_re;
    logic [AW-1:0]          ring_raddr;
    logic [BYTE_W-1:0]      ring_rdata;

    // Decisions handed to the next-state logic
    logic                   accept;
    logic                   acc_mark, acc_lit, acc_match;
    logic                   out_free;
    logic                   emit_fire, emit_limit, copy_more;
    logic                   bnd_done, bnd_trunc, bnd_mark;

    logic [AW-1:0]          src_inc;
    logic [AW-1:0]          wp_inc;
    logic [BYTE_W-1:0]      copy_byte;

    lzrd_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (wp_reg),
        .wr_data (ring_wdata),
        .rd_en   (ring_re),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    assign packed_ch.ready = (state_reg == ST_IDLE);
    assign accept          = packed_ch.valid && packed_ch.ready;

    assign decoded_ch.valid    = out_valid_reg;
    assign decoded_ch.out_byte = out_byte_reg;
    assign decoded_ch.kind     = out_kind_reg;
    assign decoded_ch.consumed = out_cons_reg;
    assign decoded_ch.last     = out_last_reg;

    // The output register may be refilled when empty or being drained
    assign out_free = !out_valid_reg || decoded_ch.ready;

    assign src_inc = src_reg + 1'b1;
    assign wp_inc  = wp_reg + 1'b1;

    // Forwarded byte covers a copy read issued in the same cycle as the write of
    // that entry; entries the stream never wrote read as zero.
    assign copy_byte = fwd_reg    ? fwd_data_reg :
                       rvalid_reg ? ring_rdata   : '0;

    // End-of-item check: an empty or overdrawn budget ends the stream, else the last byte
    // of the source is a truncation.
    assign bnd_done  = budget_reg[BUDGET_W-1] || (budget_reg == '0);
    assign bnd_trunc = !bnd_done && at_end_reg;
    assign bnd_mark  = bnd_done || bnd_trunc;

    //--------------------------------------------------------------------
    // Next state
    //--------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_mark)
                begin
                    state_next = ST_MARK;
                end
                else if (acc_lit)
                begin
                    state_next = ST_LIT;
                end
                else if (acc_match)
                begin
                    state_next = ST_MRD;
                end
            end
            ST_LIT:
            begin
                if (emit_fire)
                begin
                    state_next = (!emit_limit && bnd_mark) ? ST_MARK : ST_IDLE;
                end
            end
            ST_MRD:
            begin
                state_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (emit_fire)
                begin
                    priority if (emit_limit)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (copy_more)
                    begin
                        state_next = ST_COPY;
                    end
                    else if (bnd_mark)
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Datapath and outputs
    //--------------------------------------------------------------------
    always_comb
    begin
        logic [LEN_W-1:0]  len_v;
        logic [DIST_W-1:0] dist_v;
        logic              end_of_item;

        run_next        = run_reg;
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        held_next       = held_reg;
        budget_next     = budget_reg;
        count_next      = count_reg;
        consumed_next   = consumed_reg;
        wp_next         = wp_reg;
        full_next       = full_reg;
        at_end_next     = at_end_reg;
        src_next        = src_reg;
        remain_next     = remain_reg;
        fwd_next        = fwd_reg;
        rvalid_next     = rvalid_reg;
        mark_kind_next  = mark_kind_reg;
        mark_cons_next  = mark_cons_reg;
        lit_next        = lit_reg;
        fwd_data_next   = fwd_data_reg;

        out_valid_next  = out_valid_reg && !decoded_ch.ready;
        out_byte_next   = out_byte_reg;
        out_kind_next   = out_kind_reg;
        out_cons_next   = out_cons_reg;
        out_last_next   = out_last_reg;

        ring_we    = 1'b0;
        ring_wdata = copy_byte;
        ring_re    = 1'b0;
        ring_raddr = src_reg;

        acc_mark   = 1'b0;
        acc_lit    = 1'b0;
        acc_match  = 1'b0;
        emit_fire  = 1'b0;
        emit_limit = count_reg >= max_output_reg;
        copy_more  = remain_reg > 5'd1;

        len_v       = {1'b0, held_reg[3:0]} + 1'b1;
        dist_v      = {held_reg[7:4], packed_ch.in_byte};
        end_of_item = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    at_end_next = packed_ch.source_end;
                    if (packed_ch.stream_start)
                    begin
                        // New stream: forget the window through the fill mark
                        wp_next         = '0;
                        full_next       = 1'b0;
                        flag_bits_next  = '0;
                        flags_left_next = '0;
                        phase_next      = PH_FLAG_LO;
                        held_next       = '0;
                        budget_next     = {2'b00, packed_size_reg};
                        count_next      = '0;
                        consumed_next   = '0;
                        run_next        = RUN_ACTIVE;
                        if (packed_size_reg == '0)
                        begin
                            run_next       = RUN_DONE;
                            mark_kind_next = KIND_DONE;
                            mark_cons_next = '0;
                            acc_mark       = 1'b1;
                        end
                    end

                    if (run_next == RUN_ACTIVE)
                    begin
                        consumed_next = consumed_next + 1'b1;
                        unique case (phase_next)
                            PH_FLAG_LO:
                            begin
                                flag_bits_next[7:0] = packed_ch.in_byte;
                                phase_next          = PH_FLAG_HI;
                            end
                            PH_FLAG_HI:
                            begin
                                flag_bits_next[15:8] = packed_ch.in_byte;
                                flags_left_next      = FLAGS_PER_WORD;
                                budget_next          = budget_next - COST_FLAG;
                                phase_next           = PH_ITEM;
                            end
                            PH_ITEM:
                            begin
                                flag_bits_next = {1'b0, flag_bits_reg[15:1]};
                                if (flags_left_reg != '0)
                                begin
                                    flags_left_next = flags_left_reg - 1'b1;
                                end
                                if (!flag_bits_reg[0])
                                begin
                                    budget_next = budget_reg - COST_LITERAL;
                                    lit_next    = packed_ch.in_byte;
                                    acc_lit     = 1'b1;
                                end
                                else
                                begin
                                    held_next  = packed_ch.in_byte;
                                    phase_next = PH_MATCH2;
                                end
                            end
                            PH_MATCH2:
                            begin
                                budget_next = budget_reg - COST_MATCH;
                                remain_next = len_v;
                                src_next    = wp_reg - AW'(dist_v);
                                acc_match   = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_FLAG_LO;
                            end
                        endcase

                        // A byte that still needs a follower cannot be the last
                        if (!acc_lit && !acc_match && packed_ch.source_end)
                        begin
                            run_next       = RUN_FAIL;
                            mark_kind_next = KIND_TRUNC;
                            mark_cons_next = '0;
                            acc_mark       = 1'b1;
                        end
                    end
                end
            end

            ST_LIT, ST_COPY:
            begin
                if (out_free)
                begin
                    emit_fire = 1'b1;
                    out_valid_next = 1'b1;
                    out_cons_next  = '0;
                    if (emit_limit)
                    begin
                        // Output limit: drop the rest of the item
                        run_next      = RUN_FAIL;
                        out_byte_next = '0;
                        out_kind_next = KIND_LIMIT;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        ring_we       = 1'b1;
                        ring_wdata    = (state_reg == ST_LIT) ? lit_reg : copy_byte;
                        wp_next       = wp_inc;
                        full_next     = full_reg || (wp_reg == '1);
                        count_next    = count_reg + 1'b1;
                        out_byte_next = ring_wdata;
                        out_kind_next = KIND_DATA;
                        end_of_item   = (state_reg == ST_LIT) || !copy_more;
                        out_last_next = end_of_item && !bnd_mark;

                        if (!end_of_item)
                        begin
                            // Advance the copy; forward when reading the entry
                            // written in this same cycle
                            remain_next   = remain_reg - 1'b1;
                            src_next      = src_inc;
                            ring_re       = 1'b1;
                            ring_raddr    = src_inc;
                            fwd_next      = (src_inc == wp_reg);
                            fwd_data_next = ring_wdata;
                            rvalid_next   = full_reg || (src_inc < wp_reg);
                        end
                        else if (bnd_done)
                        begin
                            run_next       = RUN_DONE;
                            mark_kind_next = KIND_DONE;
                            mark_cons_next = consumed_reg;
                        end
                        else if (bnd_trunc)
                        begin
                            run_next       = RUN_FAIL;
                            mark_kind_next = KIND_TRUNC;
                            mark_cons_next = '0;
                        end
                        else
                        begin
                            phase_next = (flags_left_reg == '0) ? PH_FLAG_LO : PH_ITEM;
                        end
                    end
                end
            end

            ST_MRD:
            begin
                // Issue the first read of the copy
                ring_re     = 1'b1;
                ring_raddr  = src_reg;
                fwd_next    = 1'b0;
                rvalid_next = full_reg || (src_reg < wp_reg);
            end

            ST_MARK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_kind_next  = mark_kind_reg;
                    out_cons_next  = mark_cons_reg;
                    out_last_next  = 1'b1;
                end
            end

            default:
            begin
                out_valid_next = out_valid_reg && !decoded_ch.ready;
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Registers
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            run_reg         <= RUN_IDLE;
            phase_reg       <= PH_FLAG_LO;
            flag_bits_reg   <= '0;
            flags_left_reg  <= '0;
            held_reg        <= '0;
            budget_reg      <= '0;
            count_reg       <= '0;
            consumed_reg    <= '0;
            wp_reg          <= '0;
            full_reg        <= 1'b0;
            at_end_reg      <= 1'b0;
            src_reg         <= '0;
            remain_reg      <= '0;
            fwd_reg         <= 1'b0;
            rvalid_reg      <= 1'b0;
            mark_kind_reg   <= KIND_DONE;
            out_valid_reg   <= 1'b0;
            packed_size_reg <= '0;
            max_output_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            held_reg       <= held_next;
            budget_reg     <= budget_next;
            count_reg      <= count_next;
            consumed_reg   <= consumed_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            at_end_reg     <= at_end_next;
            src_reg        <= src_next;
            remain_reg     <= remain_next;
            fwd_reg        <= fwd_next;
            rvalid_reg     <= rvalid_next;
            mark_kind_reg  <= mark_kind_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PACKED_SIZE: packed_size_reg <= cfg_data;
                    CFG_MAX_OUTPUT:  max_output_reg  <= cfg_data;
                    default:         packed_size_reg <= packed_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg       <= lit_next;
        fwd_data_reg  <= fwd_data_next;
        mark_cons_reg <= mark_cons_next;
        out_byte_reg  <= out_byte_next;
        out_kind_reg  <= out_kind_next;
        out_cons_reg  <= out_cons_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* hw/rtl/lzrd_ring.sv */
// Window ring memory: one write port, one read port, registered read data.
// Depends on lzrd_pkg for the byte width.
module lzrd_ring
    import lzrd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write: a same-cycle read of the written entry sees the old byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* verif/lzss_ring_window_decoder_unit_tb.sv */
// Self-checking testbench for the LZSS ring window decoder: directed table, then random streams.
// Depends on lzrd_pkg, lzrd_in_if / lzrd_out_if and the lzss_ring_window_decoder_unit RTL.
module lzss_ring_window_decoder_unit_tb;
    import lzrd_pkg::*;

    localparam int RING      = 4096;
    localparam int DIR_ROWS  = 27;
    localparam int RAND_GOAL = 136;
    // Longest item: a 16-byte match plus its marker, with margin.
    localparam int TAIL_CYCLES = 24;
    // Worst case is far below this: ~200 items, 17 results each, long receiver stalls.
    localparam int RUN_LIMIT = 5_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0]     out_byte;
        logic [KIND_W-1:0]     kind;
        logic [CONSUMED_W-1:0] consumed;
        logic                  last;
    } dec_res_t;

    typedef enum logic [0:0] {
        ROW_BYTE,
        ROW_REG
    } row_kind_t;

    // How a directed row is checked: by the decoder model, against a typed result, or not at all.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } chk_t;

    typedef struct {
        row_kind_t         act;
        logic [BYTE_W-1:0] val;
        bit                start;
        bit                fin;
        logic              reg_sel;
        logic [CFG_W-1:0]  reg_val;
        chk_t              chk;
        logic [KIND_W-1:0] t_kind;
        logic [31:0]       t_used;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lzrd_in_if  packed_ch ();
    lzrd_out_if decoded_ch ();

    lzss_ring_window_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .packed_ch  (packed_ch),
        .decoded_ch (decoded_ch)
    );

    // ------------------------------------------------------------------
    // Decoder model state: window, parser and budget, as seen by the DUT.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]      cfg_packed = '0;
    logic [CFG_W-1:0]      cfg_max    = '0;
    logic [BYTE_W-1:0]     win_mem [RING];
    logic [DIST_W-1:0]     wr_pos     = '0;
    logic [15:0]           flag_sr    = '0;
    logic [LEN_W-1:0]      flags_rem  = '0;
    phase_t                phase      = PH_FLAG_LO;
    logic [BYTE_W-1:0]     held_b0    = '0;
    longint                budget     = 0;
    logic [CFG_W-1:0]      out_cnt    = '0;
    logic [CONSUMED_W-1:0] used_cnt   = '0;
    run_t                  run_st     = RUN_IDLE;

    dec_res_t step_q [$];       // results of the byte being decoded
    dec_res_t due_results [$];  // results the DUT still owes, oldest first

    int unsigned idle_pct    = 37;
    int unsigned fail_cnt    = 0;
    int unsigned checked_cnt = 0;
    int unsigned live_items  = 0;
    int unsigned dir_items   = 0;
    int unsigned stream_cnt  = 0;
    bit          paused_once = 1'b0;

    dir_row_t dir_tab [DIR_ROWS];

    function automatic void put_res(input logic [BYTE_W-1:0] v, input logic [KIND_W-1:0] k,
                                    input logic [CONSUMED_W-1:0] u);
        dec_res_t r;
        r.out_byte = v;
        r.kind     = k;
        r.consumed = u;
        r.last     = 1'b0;
        step_q.push_back(r);
    endfunction

    // Stream needed more bytes than it got.
    function automatic void cut_short();
        put_res('0, KIND_TRUNC, '0);
        run_st = RUN_FAIL;
    endfunction

    // Emit one decoded byte into the window, or raise the output limit error.
    function automatic bit emit_out(input logic [BYTE_W-1:0] v);
        if (out_cnt >= cfg_max)
        begin
            put_res('0, KIND_LIMIT, '0);
            run_st = RUN_FAIL;
            return 1'b0;
        end
        win_mem[wr_pos] = v;
        wr_pos++;
        out_cnt++;
        put_res(v, KIND_DATA, '0);
        return 1'b1;
    endfunction

    // End of an item: close the stream on an empty or overdrawn budget, truncate if the source ended, else go on.
    function automatic void close_item(input bit fin);
        if (budget <= 0)
        begin
            put_res('0, KIND_DONE, used_cnt);
            run_st = RUN_DONE;
        end
        else if (fin)
            cut_short();
        else
            phase = (flags_rem == 0) ? PH_FLAG_LO : PH_ITEM;
    endfunction

    // Decode one compressed byte; leaves the results it causes in step_q.
    function automatic void decode_step(input logic [BYTE_W-1:0] b, input bit st, input bit fin);
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] src;
        bit                ok;
        bit                is_match;
        int                i;
        step_q.delete();
        if (st)
        begin
            foreach (win_mem[j])
                win_mem[j] = '0;
            wr_pos    = '0;
            flag_sr   = '0;
            flags_rem = '0;
            phase     = PH_FLAG_LO;
            held_b0   = '0;
            budget    = longint'(cfg_packed);
            out_cnt   = '0;
            used_cnt  = '0;
            run_st    = RUN_ACTIVE;
            if (budget <= 0)
            begin
                put_res('0, KIND_DONE, '0);
                run_st = RUN_DONE;
            end
        end
        if (run_st == RUN_ACTIVE)
        begin
            used_cnt++;
            case (phase)
                PH_FLAG_LO:
                begin
                    flag_sr = {8'h00, b};
                    if (fin)
                        cut_short();
                    else
                        phase = PH_FLAG_HI;
                end
                PH_FLAG_HI:
                begin
                    flag_sr[15:8] = b;
                    flags_rem     = FLAGS_PER_WORD;
                    budget        -= 2;
                    if (fin)
                        cut_short();
                    else
                        phase = PH_ITEM;
                end
                PH_ITEM:
                begin
                    is_match = flag_sr[0];
                    flag_sr  = flag_sr >> 1;
                    if (flags_rem != 0)
                        flags_rem--;
                    if (!is_match)
                    begin
                        budget -= 1;
                        if (emit_out(b))
                            close_item(fin);
                    end
                    else
                    begin
                        held_b0 = b;
                        if (fin)
                            cut_short();
                        else
                            phase = PH_MATCH2;
                    end
                end
                default:
                begin
                    len      = {1'b0, held_b0[3:0]} + 5'd1;
                    distance = {held_b0[7:4], b};
                    src      = wr_pos - distance;
                    budget   -= 2;
                    ok       = 1'b1;
                    // Byte by byte, so an overlapping copy repeats what it just wrote.
                    for (i = 0; i < len && ok; i++)
                    begin
                        ok = emit_out(win_mem[src]);
                        src++;
                    end
                    if (ok)
                        close_item(fin);
                end
            endcase
        end
        if (step_q.size() > 0)
            step_q[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the timeout guard.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still due", due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check every accepted item against the oldest result due,
    // then pick the next cycle's ready at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dec_res_t want;
        if (rst_n && decoded_ch.valid && decoded_ch.ready)
        begin
            checked_cnt++;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d out_byte %02h", decoded_ch.kind,
                       decoded_ch.out_byte);
                fail_cnt++;
            end
            else
            begin
                want = due_results.pop_front();
                if (decoded_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, decoded_ch.out_byte);
                    fail_cnt++;
                end
                if (decoded_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, decoded_ch.kind);
                    fail_cnt++;
                end
                if (decoded_ch.consumed !== want.consumed)
                begin
                    $error("consumed: expected %0d, got %0d", want.consumed, decoded_ch.consumed);
                    fail_cnt++;
                end
                if (decoded_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, decoded_ch.last);
                    fail_cnt++;
                end
            end
        end
        decoded_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offer one compressed byte, idling at random first, and hold it until taken.
    // Directed rows may replace the model's results with a typed one, or expect none.
    task automatic send_item(input logic [BYTE_W-1:0] b, input bit st, input bit fin,
                             input chk_t chk = CHK_MODEL,
                             input logic [KIND_W-1:0] t_kind = KIND_DATA,
                             input logic [31:0] t_used = '0);
        dec_res_t typed;
        while ($urandom_range(99) < idle_pct)
        begin
            packed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        packed_ch.valid        <= 1'b1;
        packed_ch.in_byte      <= b;
        packed_ch.stream_start <= st;
        packed_ch.source_end   <= fin;
        @(posedge clk);
        while (!packed_ch.ready)
            @(posedge clk);
        // Accepted at this edge.
        live_items++;
        decode_step(b, st, fin);
        case (chk)
            CHK_MODEL:
                foreach (step_q[i])
                    due_results.push_back(step_q[i]);
            CHK_ONE:
            begin
                typed = '{out_byte: '0, kind: t_kind, consumed: t_used, last: 1'b1};
                due_results.push_back(typed);
            end
            default:
                ;
        endcase
    endtask

    // Drop valid and let the block drain: every result in, then its tail cycles.
    task automatic settle_block();
        packed_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        if (sel == CFG_PACKED_SIZE)
            cfg_packed = val;
        else
            cfg_max = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One random stream. Mostly well-formed: each byte follows the parser phase, so
    // three in four matches get a zero upper distance nibble. One in ten is noise.
    task automatic random_stream();
        int               span;
        int               k;
        logic [BYTE_W-1:0] b;
        bit               fin;
        if ($urandom_range(1) == 1)
        begin
            settle_block();
            case ($urandom_range(9))
                0:       write_reg(CFG_PACKED_SIZE, '0);
                1:       write_reg(CFG_PACKED_SIZE, '1);
                2:       write_reg(CFG_PACKED_SIZE, CFG_W'($urandom_range(1, 4)));
                default: write_reg(CFG_PACKED_SIZE, CFG_W'($urandom_range(5, 60)));
            endcase
            case ($urandom_range(5))
                0:       write_reg(CFG_MAX_OUTPUT, '0);
                1, 2:    write_reg(CFG_MAX_OUTPUT, CFG_W'($urandom_range(1, 40)));
                default: write_reg(CFG_MAX_OUTPUT, '1);
            endcase
        end
        span = $urandom_range(4, 40);
        stream_cnt++;
        if ($urandom_range(9) == 0)
        begin
            for (k = 0; k < span; k++)
                send_item(BYTE_W'($urandom), k == 0 || $urandom_range(7) == 0,
                          $urandom_range(3) == 0);
        end
        else
        begin
            send_item(BYTE_W'($urandom), 1'b1, $urandom_range(29) == 0);
            for (k = 1; k < span && run_st == RUN_ACTIVE; k++)
            begin
                // Once, hold the sender mid-stream until the block has caught up.
                if (!paused_once && live_items - dir_items >= 30)
                begin
                    settle_block();
                    paused_once = 1'b1;
                end
                b = BYTE_W'($urandom);
                if (phase == PH_ITEM && flag_sr[0])
                    b[7:4] = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0;
                fin = (k == span - 1) ? ($urandom_range(3) != 0) : ($urandom_range(29) == 0);
                send_item(b, 1'b0, fin);
            end
        end
        // Sometimes a stray byte with no start while stopped: it must be dropped.
        if (run_st != RUN_ACTIVE && $urandom_range(3) == 0)
            send_item(BYTE_W'($urandom), 1'b0, $urandom_range(1) == 1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_PACKED_SIZE;
        cfg_data               = '0;
        packed_ch.valid        = 1'b0;
        packed_ch.in_byte      = '0;
        packed_ch.stream_start = 1'b0;
        packed_ch.source_end   = 1'b0;
        decoded_ch.ready       = 1'b0;
        foreach (win_mem[j])
            win_mem[j] = '0;

        // Directed rows. Typed results: markers after reset, at the extremes and on errors.
        dir_tab = '{
            // empty budget right after reset: done at once, byte not used
            '{ROW_BYTE, 8'hA5, 1, 0, CFG_PACKED_SIZE, '0, CHK_ONE, KIND_DONE, 32'd0},
            // stopped stream drops a byte without start
            '{ROW_BYTE, 8'h5A, 0, 0, CFG_PACKED_SIZE, '0, CHK_NONE, KIND_DATA, 32'd0},
            '{ROW_REG, 8'h00, 0, 0, CFG_PACKED_SIZE, '1, CHK_MODEL, KIND_DATA, 32'd0},
            // input ends on a flag low byte
            '{ROW_BYTE, 8'h00, 1, 1, CFG_PACKED_SIZE, '0, CHK_ONE, KIND_TRUNC, 32'd0},
            // output limit still zero: the first literal trips it
            '{ROW_BYTE, 8'h00, 1, 0, CFG_PACKED_SIZE, '0, CHK_NONE, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h00, 0, 0, CFG_PACKED_SIZE, '0, CHK_NONE, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'hFF, 0, 0, CFG_PACKED_SIZE, '0, CHK_ONE, KIND_LIMIT, 32'd0},
            '{ROW_REG, 8'h00, 0, 0, CFG_MAX_OUTPUT, '1, CHK_MODEL, KIND_DATA, 32'd0},
            // flags A2 80: lit, match, lit, lit, lit, match, lit, match
            '{ROW_BYTE, 8'hA2, 1, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h80, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'hFF, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            // longest distance, one byte: reads the cleared part of the window
            '{ROW_BYTE, 8'hF0, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'hFF, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h00, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h7E, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h01, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            // sixteen bytes at distance one: overlapping copy repeats the last byte
            '{ROW_BYTE, 8'h0F, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h01, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h3C, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            // distance zero, then input ends with budget left
            '{ROW_BYTE, 8'h00, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h00, 0, 1, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            // budget 3: a started match finishes and overdraws, then done
            '{ROW_REG, 8'h00, 0, 0, CFG_PACKED_SIZE, 31'd3, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h01, 1, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h00, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h12, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h01, 0, 0, CFG_PACKED_SIZE, '0, CHK_MODEL, KIND_DATA, 32'd0},
            '{ROW_BYTE, 8'h33, 0, 1, CFG_PACKED_SIZE, '0, CHK_NONE, KIND_DATA, 32'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].act == ROW_REG)
            begin
                // Registers change only with the block idle.
                settle_block();
                write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            end
            else
                send_item(dir_tab[i].val, dir_tab[i].start, dir_tab[i].fin, dir_tab[i].chk,
                          dir_tab[i].t_kind, dir_tab[i].t_used);
        end
        dir_items = live_items;

        // Random streams; a calm stretch in the middle with no idling on either side.
        while (live_items - dir_items < RAND_GOAL)
        begin
            idle_pct = (live_items - dir_items >= 60 && live_items - dir_items < 100) ? 0 : 37;
            random_stream();
        end
        idle_pct = 37;

        settle_block();
        $display("Covered %0d directed and %0d random stream bytes over %0d random streams,",
                 dir_items, live_items - dir_items, stream_cnt);
        $display("with %0d decoded results compared field by field.", checked_cnt);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
